// File: rtl/layer_pixel_mixer_defines.svh
// assertion macros shared by the mixer modules
// each macro expects i_clk and i_rst_n in scope
`ifndef LAYER_PIXEL_MIXER_DEFINES_SVH
`define LAYER_PIXEL_MIXER_DEFINES_SVH

// same-cycle implication
`define LPM_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpm check failed");

// next-cycle implication
`define LPM_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpm check failed");

`endif

// File: rtl/lpm_pkg.sv
package lpm_pkg;

    localparam int DATA_W        = 8;
    localparam int WORD_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CNT_W         = 3;
    localparam int NUM_WORD_REGS = 4;
    localparam int MAX_STEPS_DEF = 4;
    localparam int CELL_LAT      = 4;

    localparam logic [DATA_W-1:0] FULL = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_WORD_0 = 3'd1;

    localparam logic [7:0] OP_MUL3    = 8'd0;
    localparam logic [7:0] OP_SCALE_S = 8'd1;
    localparam logic [7:0] OP_SCALE_D = 8'd2;
    localparam logic [7:0] OP_MIN     = 8'd3;
    localparam logic [7:0] OP_MAX     = 8'd4;
    localparam logic [7:0] OP_NEG_S   = 8'd5;
    localparam logic [7:0] OP_NEG_D   = 8'd6;
    localparam logic [7:0] OP_THR_S   = 8'd7;
    localparam logic [7:0] OP_THR_D   = 8'd8;

    typedef enum logic [1:0] {
        K_PASS,
        K_MUL3,
        K_SRC,
        K_DST
    } t_kind;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] d;
    } t_beat;

    // floor(x / 255) for x below 255 * 2**16, estimate plus one correction
    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [24:0] sum;
        logic [23:0] q0;
        logic [31:0] prod;
        logic [31:0] rem;
        sum  = {1'b0, x} + 25'(x >> 8) + 25'(x >> 16);
        q0   = sum[24:1] >> 7;
        prod = ({8'b0, q0} << 8) - {8'b0, q0};
        rem  = {8'b0, x} - prod;
        if (rem >= 32'd255) begin
            q0 = q0 + 24'd1;
        end
        return q0[15:0];
    endfunction

endpackage

// File: rtl/lpm_cfg.sv
module lpm_cfg #(
    parameter int MAX_STEPS = lpm_pkg::MAX_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [lpm_pkg::CFG_IDX_W-1:0]        i_idx,
    input  logic [lpm_pkg::WORD_W-1:0]           i_data,
    output logic [lpm_pkg::CNT_W-1:0]            o_count,
    output logic [MAX_STEPS-1:0][lpm_pkg::WORD_W-1:0] o_words
);

    logic [lpm_pkg::CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_we && i_idx == lpm_pkg::CFG_STEP_COUNT) begin
            r_count <= i_data[lpm_pkg::CNT_W-1:0];
        end
    end

    assign o_count = r_count;

    for (genvar g = 0; g < MAX_STEPS; g++) begin : g_word
        if (g < lpm_pkg::NUM_WORD_REGS) begin : g_reg
            logic [lpm_pkg::WORD_W-1:0] r_word;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_word <= '0;
                end else if (i_we && i_idx == lpm_pkg::CFG_STEP_WORD_0 + lpm_pkg::CFG_IDX_W'(g)) begin
                    r_word <= i_data;
                end
            end
            assign o_words[g] = r_word;
        end else begin : g_zero
            // no register behind this step, opcode 0 with parameter 0
            assign o_words[g] = '0;
        end
    end

endmodule

// File: rtl/lpm_cell.sv
`include "layer_pixel_mixer_defines.svh"

module lpm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_active,
    input  logic [lpm_pkg::WORD_W-1:0] i_word,
    input  lpm_pkg::t_beat             i_beat,
    output lpm_pkg::t_beat             o_beat
);

    logic [7:0]                 w_opc;
    logic [7:0]                 w_p;
    logic [lpm_pkg::DATA_W-1:0] w_lo;
    logic [lpm_pkg::DATA_W-1:0] w_hi;

    lpm_pkg::t_kind             n_kind1;
    logic [15:0]                n_m1;
    logic [lpm_pkg::DATA_W-1:0] n_d1;

    logic                       r_v1, r_v2, r_v3, r_v4;
    lpm_pkg::t_kind             r_kind1, r_kind2, r_kind3;
    logic [lpm_pkg::DATA_W-1:0] r_s1, r_s2, r_s3, r_s4;
    logic [lpm_pkg::DATA_W-1:0] r_d1, r_d2, r_d3, r_d4;
    logic [7:0]                 r_p1;
    logic [15:0]                r_m1;
    logic [23:0]                r_m2;
    logic [15:0]                r_a3;
    logic [15:0]                w_a4;

    assign w_opc = i_word[15:8];
    assign w_p   = i_word[7:0];
    assign w_lo  = (i_beat.s < i_beat.d) ? i_beat.s : i_beat.d;
    assign w_hi  = (i_beat.s < i_beat.d) ? i_beat.d : i_beat.s;

    // stage 1: decode and pick the operand
    always_comb begin
        n_kind1 = lpm_pkg::K_PASS;
        n_m1    = '0;
        n_d1    = i_beat.d;
        if (i_active) begin
            unique case (w_opc)
                lpm_pkg::OP_MUL3: begin
                    n_kind1 = lpm_pkg::K_MUL3;
                    n_m1    = 16'(i_beat.s) * 16'(i_beat.d);
                end
                lpm_pkg::OP_SCALE_S: begin
                    n_kind1 = lpm_pkg::K_SRC;
                    n_m1    = 16'(i_beat.s);
                end
                lpm_pkg::OP_SCALE_D: begin
                    n_kind1 = lpm_pkg::K_DST;
                    n_m1    = 16'(i_beat.d);
                end
                lpm_pkg::OP_MIN: begin
                    n_kind1 = lpm_pkg::K_DST;
                    n_m1    = 16'(w_lo);
                end
                lpm_pkg::OP_MAX: begin
                    n_kind1 = lpm_pkg::K_DST;
                    n_m1    = 16'(w_hi);
                end
                lpm_pkg::OP_NEG_S: begin
                    n_kind1 = lpm_pkg::K_SRC;
                    n_m1    = 16'(lpm_pkg::FULL - i_beat.s);
                end
                lpm_pkg::OP_NEG_D: begin
                    n_kind1 = lpm_pkg::K_DST;
                    n_m1    = 16'(lpm_pkg::FULL - i_beat.d);
                end
                lpm_pkg::OP_THR_D: begin
                    n_d1 = (i_beat.d >= w_p) ? lpm_pkg::FULL : '0;
                end
                default: begin
                    n_kind1 = lpm_pkg::K_PASS;
                end
            endcase
        end
    end

    assign w_a4 = lpm_pkg::div255({8'b0, r_a3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_beat.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        // stage 1
        r_kind1 <= n_kind1;
        r_s1    <= i_beat.s;
        r_d1    <= n_d1;
        r_p1    <= w_p;
        r_m1    <= n_m1;
        // stage 2: product with the parameter
        r_kind2 <= r_kind1;
        r_s2    <= r_s1;
        r_d2    <= r_d1;
        r_m2    <= 24'(r_m1) * 24'(r_p1);
        // stage 3: first divide by 255
        r_kind3 <= r_kind2;
        r_s3    <= r_s2;
        r_d3    <= r_d2;
        r_a3    <= lpm_pkg::div255(r_m2);
        // stage 4: second divide for the triple product, write back
        r_s4    <= (r_kind3 == lpm_pkg::K_SRC) ? r_a3[7:0] : r_s3;
        case (r_kind3)
            lpm_pkg::K_MUL3: r_d4 <= w_a4[7:0];
            lpm_pkg::K_DST:  r_d4 <= r_a3[7:0];
            default:         r_d4 <= r_d3;
        endcase
    end

    assign o_beat.valid = r_v4;
    assign o_beat.s     = r_s4;
    assign o_beat.d     = r_d4;

    `LPM_CHECK_NOW(a_cell_valid_origin, o_beat.valid, $past(i_beat.valid, 4))
    `LPM_CHECK_NOW(a_cell_idle_pass, o_beat.valid && $past(!i_active, 4), (o_beat.s == $past(i_beat.s, 4)) && (o_beat.d == $past(i_beat.d, 4)))
    `LPM_CHECK_NOW(a_cell_thr_level, $past(i_beat.valid && i_active && (w_opc == lpm_pkg::OP_THR_D), 4), o_beat.valid && ((o_beat.d == lpm_pkg::FULL) || (o_beat.d == '0)))

endmodule

// File: rtl/layer_pixel_mixer.sv
// start passes through the entry register and then each step cell in turn to o_valid
// throughput: one pixel pair per cycle, busy never rises
// each step cell is a four stage pipe: operand, multiply, divide by 255, write back
// reset clears the step count, the step words and all beat valid flags
`include "layer_pixel_mixer_defines.svh"

module layer_pixel_mixer #(
    parameter int MAX_STEPS = lpm_pkg::MAX_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [lpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lpm_pkg::WORD_W-1:0]    i_cfg_data,
    input  logic [lpm_pkg::DATA_W-1:0]    i_layer_pixel,
    input  logic [lpm_pkg::DATA_W-1:0]    i_frame_pixel,
    output logic                          o_valid,
    output logic [lpm_pkg::DATA_W-1:0]    o_mixed_pixel,
    output logic [lpm_pkg::DATA_W-1:0]    o_layer_after
);

    localparam int LAT = 1 + lpm_pkg::CELL_LAT * MAX_STEPS;

    logic [lpm_pkg::CNT_W-1:0]                 w_count;
    logic [MAX_STEPS-1:0][lpm_pkg::WORD_W-1:0] w_words;
    logic [MAX_STEPS-1:0]                      w_active;
    lpm_pkg::t_beat                            r_in;
    lpm_pkg::t_beat                            w_chain [MAX_STEPS+1];

    lpm_cfg #(
        .MAX_STEPS (MAX_STEPS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_count (w_count),
        .o_words (w_words)
    );

    assign busy = 1'b0;

    // entry beat, zero steps copies source into destination
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= start;
        end
        r_in.s <= i_layer_pixel;
        r_in.d <= (w_count == '0) ? i_layer_pixel : i_frame_pixel;
    end

    assign w_chain[0] = r_in;

    for (genvar g = 0; g < MAX_STEPS; g++) begin : g_cell
        assign w_active[g] = ({2'b00, w_count} > 5'(g));

        lpm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (w_active[g]),
            .i_word   (w_words[g]),
            .i_beat   (w_chain[g]),
            .o_beat   (w_chain[g+1])
        );
    end

    assign o_valid       = w_chain[MAX_STEPS].valid;
    assign o_mixed_pixel = w_chain[MAX_STEPS].d;
    assign o_layer_after = w_chain[MAX_STEPS].s;

    `LPM_CHECK_NOW(a_out_origin, o_valid, $past(start, LAT))
    `LPM_CHECK_NEXT(a_entry_valid, start, r_in.valid)
    `LPM_CHECK_NEXT(a_entry_copy, start && (w_count == '0), r_in.d == r_in.s)

endmodule
